[sv/kss_pkg.sv]
// kss_pkg: shared types, constants and helpers for the order-statistic selector
// no dependencies
`default_nettype none
package kss_pkg;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned RankWidth  = 6;

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [RankWidth-1:0]  rank_t;

  // sequencer state codes
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCand  = 2'd1;
  localparam logic [1:0] StLatch = 2'd2;
  localparam logic [1:0] StScan  = 2'd3;

  // flip sign bit so an unsigned compare gives signed order
  function automatic value_t order_key(input value_t v);
    order_key = v ^ {1'b1, {(ValueWidth-1){1'b0}}};
  endfunction
endpackage
`default_nettype wire

[sv/kss_store.sv]
// kss_store: value memory with one write port and one registered read port, one write and one read per cycle
// depends on kss_pkg
`default_nettype none
module kss_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire               clk_i,
  input  wire               wr_en_i,
  input  wire  [AddrW-1:0]  wr_addr_i,
  input  kss_pkg::value_t   wr_data_i,
  input  wire               rd_en_i,
  input  wire  [AddrW-1:0]  rd_addr_i,
  output kss_pkg::value_t   rd_data_o
);
  import kss_pkg::*;

  value_t mem_q [Depth];
  value_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule
`default_nettype wire

[sv/kth_smallest_select.sv]
// kth_smallest_select: top level, loads a set of signed values and selects by rank
// depends on kss_pkg and kss_store
//
// usage: raise start with sample_value_i for each element; a request is taken
// when start is high and busy is low. the request with is_last_i high also
// carries target_rank_i and closes the set.
// loading runs at one element per cycle into the value memory; elements past
// MAX_ELEMENTS are dropped.
// a rank at or beyond the element count gives a result in the cycle after the
// last request with rank_error_o high and zero value, busy stays low.
// otherwise the sequencer tests candidates in memory order: for each it scans
// all n entries through the single read port and counts the entries ranked
// below it (ties broken by position). the candidate whose count equals the
// rank is emitted. each candidate passes StCand, StLatch and StScan, so a
// selection tests between one and n candidates, bounded by the memory port.
// the result is shown for one cycle on result_valid_o; the receiver cannot
// stall. after the result the store is empty for the next set.
// reset empties the store and returns the sequencer to idle.
`default_nettype none
module kth_smallest_select #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start,
  output logic             busy,
  input  kss_pkg::value_t  sample_value_i,
  input  wire              is_last_i,
  input  kss_pkg::rank_t   target_rank_i,
  output logic             result_valid_o,
  output kss_pkg::value_t  selected_value_o,
  output logic             rank_error_o
);
  import kss_pkg::*;

  localparam int unsigned AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ELEMENTS + 1) + 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ELEMENTS);

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;   // elements loaded
  logic [CntW-1:0] n_q, n_d;           // set size under selection
  logic [CntW-1:0] rank_q, rank_d;
  logic [CntW-1:0] cand_q, cand_d;     // candidate index
  logic [CntW-1:0] issue_q, issue_d;   // next scan read index
  logic [CntW-1:0] pidx_q, pidx_d;     // index of data on the read port
  logic            pend_q, pend_d;
  logic [CntW-1:0] less_q, less_d;
  value_t          cval_q, cval_d;
  logic            rv_q, rv_d;
  logic            rerr_q, rerr_d;
  value_t          rval_q, rval_d;

  logic            req;
  logic            wr_en;
  logic [CntW-1:0] n_new;
  logic            rd_en;
  logic [CntW-1:0] rd_idx;
  value_t          rd_data;

  assign req   = start && !busy;
  assign wr_en = req && (count_q < MaxCnt);
  assign n_new = wr_en ? count_q + CntW'(1) : count_q;

  kss_store #(
    .Depth (MAX_ELEMENTS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i (sample_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    rank_d  = rank_q;
    cand_d  = cand_q;
    issue_d = issue_q;
    pidx_d  = pidx_q;
    pend_d  = pend_q;
    less_d  = less_q;
    cval_d  = cval_q;
    rv_d    = 1'b0;
    rerr_d  = rerr_q;
    rval_d  = rval_q;
    rd_en   = 1'b0;
    rd_idx  = issue_q;
    case (state_q)
      StIdle: begin
        if (req) begin
          count_d = n_new;
          if (is_last_i) begin
            count_d = '0;
            n_d     = n_new;
            rank_d  = CntW'(target_rank_i);
            if (CntW'(target_rank_i) >= n_new) begin
              // rank out of range
              rv_d   = 1'b1;
              rerr_d = 1'b1;
              rval_d = '0;
            end else begin
              cand_d  = '0;
              state_d = StCand;
            end
          end
        end
      end
      StCand: begin
        rd_en   = 1'b1;
        rd_idx  = cand_q;
        state_d = StLatch;
      end
      StLatch: begin
        cval_d  = rd_data;
        less_d  = '0;
        rd_en   = 1'b1;
        rd_idx  = '0;
        pidx_d  = '0;
        pend_d  = 1'b1;
        issue_d = CntW'(1);
        state_d = StScan;
      end
      StScan: begin
        if (pend_q) begin
          if ((order_key(rd_data) < order_key(cval_q)) ||
              ((rd_data == cval_q) && (pidx_q < cand_q))) begin
            less_d = less_q + CntW'(1);
          end
        end
        if (issue_q < n_q) begin
          rd_en   = 1'b1;
          pidx_d  = issue_q;
          pend_d  = 1'b1;
          issue_d = issue_q + CntW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            // scan complete for this candidate
            if (less_q == rank_q) begin
              rv_d    = 1'b1;
              rerr_d  = 1'b0;
              rval_d  = cval_q;
              state_d = StIdle;
            end else begin
              cand_d  = cand_q + CntW'(1);
              state_d = StCand;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      pend_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    rank_q  <= rank_d;
    cand_q  <= cand_d;
    issue_q <= issue_d;
    pidx_q  <= pidx_d;
    less_q  <= less_d;
    cval_q  <= cval_d;
    rerr_q  <= rerr_d;
    rval_q  <= rval_d;
  end

  assign busy             = (state_q != StIdle);
  assign result_valid_o   = rv_q;
  assign selected_value_o = rval_q;
  assign rank_error_o     = rerr_q;
endmodule
`default_nettype wire

[sv/kss_checker.sv]
// kss_checker: port-level checks for kth_smallest_select, bound to the top level
// depends on kss_pkg
`default_nettype none
module kss_checker (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              start,
  input wire              busy,
  input wire              is_last_i,
  input wire              result_valid_o,
  input kss_pkg::value_t  selected_value_o,
  input wire              rank_error_o
);
  import kss_pkg::*;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rank_error_o |-> selected_value_o == '0)
    else $error("error result with nonzero value");

  a_no_res_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !is_last_i |=> !result_valid_o)
    else $error("result after a non-last request");

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while busy");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && is_last_i))
    else $error("busy without a last request");
endmodule

bind kth_smallest_select kss_checker u_kss_checker (.*);
`default_nettype wire
